// ===== sv/bts_pkg.sv =====
// Shared codes, limits, note tables and duty scaling for the buzzer tone sequencer.
package bts_pkg;

    typedef logic [2:0] t_mode;
    typedef logic [1:0] t_status;
    typedef logic [1:0] t_cfg_addr;

    // Item kinds carried in tuser.
    localparam t_mode MODE_TICK    = 3'd0;
    localparam t_mode MODE_TONE    = 3'd1;
    localparam t_mode MODE_BEEP    = 3'd2;
    localparam t_mode MODE_PATTERN = 3'd3;
    localparam t_mode MODE_OFF     = 3'd4;

    // Result status codes.
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_INVALID  = 2'd1;
    localparam t_status ST_REJECTED = 2'd2;

    // Register indexes.
    localparam t_cfg_addr CFG_BEEP_DUTY    = 2'd0;
    localparam t_cfg_addr CFG_PATTERN_DUTY = 2'd1;
    localparam t_cfg_addr CFG_REPEAT_GAP   = 2'd2;

    localparam logic [15:0] FREQ_MIN = 16'd20;
    localparam logic [15:0] FREQ_MAX = 16'd20000;
    localparam logic [13:0] BEEP_MIN = 14'd10;
    localparam logic [13:0] BEEP_MAX = 14'd10000;

    localparam logic [14:0] RESET_FREQ       = 15'd2000;
    localparam logic [9:0]  RESET_BEEP_DUTY  = 10'd511;   // 50 percent
    localparam logic [9:0]  RESET_PAT_DUTY   = 10'd818;   // 80 percent
    localparam logic [9:0]  RESET_REPEAT_GAP = 10'd120;

    // Notes in one repeat of the falling pattern (1 to 8).
    localparam int PATTERN_NOTES = 4;

    function automatic logic [10:0] note_freq(input logic [2:0] idx);
        logic [10:0] f;
        unique case (idx)
            3'd0: f = 11'd1400;
            3'd1: f = 11'd1000;
            3'd2: f = 11'd800;
            3'd3: f = 11'd600;
            3'd4: f = 11'd500;
            3'd5: f = 11'd400;
            3'd6: f = 11'd300;
            3'd7: f = 11'd200;
            default: f = 11'd200;
        endcase
        return f;
    endfunction

    function automatic logic [5:0] note_ms(input logic [2:0] idx);
        logic [5:0] ms;
        unique case (idx)
            3'd0: ms = 6'd30;
            3'd1: ms = 6'd30;
            3'd2: ms = 6'd40;
            default: ms = 6'd60;
        endcase
        return ms;
    endfunction

    // floor(1023 * min(p, 100) / 100) = 10p + floor(23p / 100);
    // floor(23p / 100) is taken as (p * 23 * 1311) >> 17, exact for p <= 100.
    function automatic logic [9:0] duty_of(input logic [7:0] pct);
        logic [6:0]  p;
        logic [21:0] prod;
        logic [9:0]  tens;
        p    = (pct > 8'd100) ? 7'd100 : pct[6:0];
        prod = 22'(p) * 22'd30153;
        tens = 10'(p) * 10'd10;
        return tens + 10'(prod[21:17]);
    endfunction

endpackage

// ===== sv/buzzer_tone_sequencer_top.sv =====
// Buzzer tone sequencer: command and tick stream in, programmed tone and duty out.
//
//  channel   | dir | tdata (low bit up)                          | tuser
//  s_axis    | in  | frequency 16, duty_pct 8, duration 14,      | mode 3
//            |     | repeats 8, 2 zero bits (48 bits)            |
//  m_axis    | out | tone_frequency 15, duty_value 10, busy_res 1,| status 2
//            |     | 6 zero bits (32 bits)                        |
//  cfg       | in  | i_cfg_we, i_cfg_addr, i_cfg_data (10 bits)   | -
//
// Each transfer yields one result transfer when m_axis is ready: the item waits in the input
// register, then update logic loads the result register; accept one item per cycle while
// m_axis takes the results. Update logic is compares, counter decrements and one
// constant-scaled tone duty multiply; beep and pattern duties are scaled on write.
// Synchronous active-low reset restores default registers and silences the tone at
// 2000 Hz. A stalled result holds; an item behind it holds too and drops s_axis tready.
module buzzer_tone_sequencer_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // cfg write port
    input  logic                  i_cfg_we,
    input  bts_pkg::t_cfg_addr    i_cfg_addr,
    input  logic [9:0]            i_cfg_data,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [47:0]           i_s_axis_tdata,  // frequency, duty_pct, duration, repeats
    input  bts_pkg::t_mode        i_s_axis_tuser,  // mode
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [31:0]           o_m_axis_tdata,  // tone_frequency, duty_value, busy_res
    output bts_pkg::t_status      o_m_axis_tuser   // status
);
    import bts_pkg::*;

    // Input register.
    logic        r_in_valid;
    t_mode       r_in_mode;
    logic [15:0] r_in_freq;
    logic [7:0]  r_in_duty;
    logic [13:0] r_in_dur;
    logic [7:0]  r_in_reps;

    // Scaled configuration.
    logic [9:0]  r_beep_duty;
    logic [9:0]  r_pat_duty;
    logic [9:0]  r_repeat_gap;

    // Sequencer state.
    logic [14:0] r_freq,      n_freq;
    logic [9:0]  r_duty,      n_duty;
    logic [13:0] r_beep_left, n_beep_left;
    logic        r_pat_active, n_pat_active;
    logic [2:0]  r_note_idx,  n_note_idx;
    logic [9:0]  r_phase_left, n_phase_left;
    logic [7:0]  r_reps_left, n_reps_left;
    logic        r_in_gap,    n_in_gap;

    // Result register.
    logic        r_out_valid;
    t_status     r_out_status;
    logic [14:0] r_out_freq;
    logic [9:0]  r_out_duty;
    logic        r_out_busy;

    logic        in_load;
    logic        advance;
    t_status     n_status;
    logic        do_play;
    logic [2:0]  play_idx;
    logic [9:0]  phase_dec;
    logic        freq_ok;
    logic        dur_ok;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_load         = i_s_axis_tvalid && o_s_axis_tready;

    assign freq_ok = (r_in_freq >= FREQ_MIN) && (r_in_freq <= FREQ_MAX);
    assign dur_ok  = (r_in_dur >= BEEP_MIN) && (r_in_dur <= BEEP_MAX);

    // Capture the incoming transfer; drop the item once it moves to the update stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_mode <= i_s_axis_tuser;
            r_in_freq <= i_s_axis_tdata[15:0];
            r_in_duty <= i_s_axis_tdata[23:16];
            r_in_dur  <= i_s_axis_tdata[37:24];
            r_in_reps <= i_s_axis_tdata[45:38];
        end
    end

    // Scale duty percents at write time so the item path never multiplies them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beep_duty  <= RESET_BEEP_DUTY;
            r_pat_duty   <= RESET_PAT_DUTY;
            r_repeat_gap <= RESET_REPEAT_GAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BEEP_DUTY:    r_beep_duty  <= duty_of({1'b0, i_cfg_data[6:0]});
                CFG_PATTERN_DUTY: r_pat_duty   <= duty_of({1'b0, i_cfg_data[6:0]});
                CFG_REPEAT_GAP:   r_repeat_gap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next-state logic for one item.
    always_comb begin
        n_freq       = r_freq;
        n_duty       = r_duty;
        n_beep_left  = r_beep_left;
        n_pat_active = r_pat_active;
        n_note_idx   = r_note_idx;
        n_phase_left = r_phase_left;
        n_reps_left  = r_reps_left;
        n_in_gap     = r_in_gap;
        n_status     = ST_OK;
        do_play      = 1'b0;
        play_idx     = 3'd0;
        phase_dec    = (r_phase_left != 10'd0) ? r_phase_left - 10'd1 : r_phase_left;

        unique case (r_in_mode)
            MODE_TICK: begin
                // Beep countdown: silence on expiry.
                if (r_beep_left != 14'd0) begin
                    n_beep_left = r_beep_left - 14'd1;
                    if (r_beep_left == 14'd1) begin
                        n_duty = 10'd0;
                    end
                end
                // Pattern phase: next note, gap, or end of a repeat.
                if (r_pat_active) begin
                    n_phase_left = phase_dec;
                    if (phase_dec == 10'd0) begin
                        if (r_in_gap) begin
                            do_play = 1'b1;
                        end else if (({1'b0, r_note_idx} + 4'd1) < 4'(PATTERN_NOTES)) begin
                            do_play  = 1'b1;
                            play_idx = r_note_idx + 3'd1;
                        end else begin
                            n_duty      = 10'd0;
                            n_reps_left = r_reps_left - 8'd1;
                            if (r_reps_left == 8'd1) begin
                                n_pat_active = 1'b0;
                                n_in_gap     = 1'b0;
                                n_phase_left = 10'd0;
                            end else if (r_repeat_gap == 10'd0) begin
                                do_play = 1'b1;
                            end else begin
                                n_in_gap     = 1'b1;
                                n_phase_left = r_repeat_gap;
                            end
                        end
                    end
                end
            end
            MODE_TONE: begin
                if (!freq_ok) begin
                    n_status = ST_INVALID;
                end else begin
                    n_beep_left  = 14'd0;
                    n_pat_active = 1'b0;
                    n_in_gap     = 1'b0;
                    n_phase_left = 10'd0;
                    n_reps_left  = 8'd0;
                    n_freq       = r_in_freq[14:0];
                    n_duty       = duty_of(r_in_duty);
                end
            end
            MODE_BEEP: begin
                if (!dur_ok) begin
                    n_status = ST_INVALID;
                end else begin
                    // Cancel the pattern even when the frequency is rejected.
                    n_pat_active = 1'b0;
                    n_in_gap     = 1'b0;
                    n_phase_left = 10'd0;
                    n_reps_left  = 8'd0;
                    if (!freq_ok) begin
                        n_status = ST_REJECTED;
                    end else begin
                        n_freq      = r_in_freq[14:0];
                        n_duty      = r_beep_duty;
                        n_beep_left = r_in_dur;
                    end
                end
            end
            MODE_PATTERN: begin
                if (r_in_reps == 8'd0) begin
                    n_status = ST_INVALID;
                end else begin
                    n_beep_left  = 14'd0;
                    n_pat_active = 1'b1;
                    n_reps_left  = r_in_reps;
                    do_play      = 1'b1;
                end
            end
            MODE_OFF: begin
                n_beep_left  = 14'd0;
                n_pat_active = 1'b0;
                n_in_gap     = 1'b0;
                n_phase_left = 10'd0;
                n_reps_left  = 8'd0;
                n_duty       = 10'd0;
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase

        // Start a pattern note.
        if (do_play) begin
            n_note_idx   = play_idx;
            n_freq       = 15'(note_freq(play_idx));
            n_duty       = r_pat_duty;
            n_phase_left = 10'(note_ms(play_idx));
            n_in_gap     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq       <= RESET_FREQ;
            r_duty       <= 10'd0;
            r_beep_left  <= 14'd0;
            r_pat_active <= 1'b0;
            r_note_idx   <= 3'd0;
            r_phase_left <= 10'd0;
            r_reps_left  <= 8'd0;
            r_in_gap     <= 1'b0;
        end else if (advance) begin
            r_freq       <= n_freq;
            r_duty       <= n_duty;
            r_beep_left  <= n_beep_left;
            r_pat_active <= n_pat_active;
            r_note_idx   <= n_note_idx;
            r_phase_left <= n_phase_left;
            r_reps_left  <= n_reps_left;
            r_in_gap     <= n_in_gap;
        end
    end

    // Result register: load on advance, release on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_status <= n_status;
            r_out_freq   <= n_freq;
            r_out_duty   <= n_duty;
            r_out_busy   <= (n_beep_left != 14'd0) || n_pat_active;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {6'd0, r_out_busy, r_out_duty, r_out_freq};

endmodule

// ===== sv/bts_checker.sv =====
// Port-level checks for the buzzer tone sequencer, bound to the top level.
module bts_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [31:0]           o_m_axis_tdata,
    input bts_pkg::t_status      o_m_axis_tuser
);
    import bts_pkg::*;

    // Input side stalls only behind a held result.
    a_stall_behind_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with no result pending");

    // A result that is not taken holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // Status is one of the three defined codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tuser == ST_OK) || (o_m_axis_tuser == ST_INVALID) ||
            (o_m_axis_tuser == ST_REJECTED))
        else $error("undefined status code");

    // Programmed frequency stays within the tone generator range.
    a_freq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[14:0] >= 15'(FREQ_MIN)) &&
            (o_m_axis_tdata[14:0] <= 15'(FREQ_MAX)))
        else $error("tone frequency out of range");

endmodule

bind buzzer_tone_sequencer_top bts_checker u_bts_checker (.*);
